// ===== rtl/hpcs_pkg.sv =====
// Shared types, constants and result formatting for the highest-pt candidate selector.
package hpcs_pkg;

    localparam int PT_LEVELS_DEF = 15;
    localparam int PRE_SLOTS_DEF = 2;
    localparam int OUT_SLOTS_DEF = 2;

    localparam int PT_W      = 4;
    localparam int IN_DATA_W = 24;
    localparam int OUT_DATA_W = 32;
    localparam int ADDR_W    = 3;

    localparam logic REG_REGION_IS_ENDCAP = 1'b0;  // paddr[2] of register 0

    typedef struct packed {
        logic [4:0] ssc;
        logic       rb;
        logic [1:0] phi;
        logic [4:0] dr;
        logic [3:0] dphi;
        logic       veto;
    } payload_t;

    typedef struct packed {
        logic              veto;
        logic [3:0]        dphi;
        logic [5:0]        dr;
        logic [1:0]        phi;
        logic [6:0]        r;
        logic [PT_W-1:0]   lvl;
        logic              found;
        logic              rank;
    } result_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FETCH,
        ST_FLUSH
    } state_t;

    function automatic result_t fmt_result(payload_t p, logic [PT_W-1:0] lvl,
                                           logic rank, logic endcap);
        result_t res;
        res.veto  = p.veto;
        res.dphi  = p.dphi;
        res.dr    = {p.dr, 1'b0};
        res.phi   = p.phi;
        res.r     = {1'b0, p.ssc, p.rb} - {6'b0, endcap};
        res.lvl   = lvl;
        res.found = 1'b1;
        res.rank  = rank;
        return res;
    endfunction

endpackage

// ===== rtl/hpcs_slot_store.sv =====
// Candidate slot storage: hit flags in flops, payloads in a small memory.
module hpcs_slot_store #(
    parameter int NSLOTS = hpcs_pkg::PT_LEVELS_DEF * hpcs_pkg::PRE_SLOTS_DEF,
    parameter int IDX_W  = (NSLOTS > 1) ? $clog2(NSLOTS) : 1
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               wr_en,
    input  logic [IDX_W-1:0]   wr_idx,
    input  logic               wr_hit,
    input  hpcs_pkg::payload_t wr_data,
    input  logic               clear,
    input  logic [IDX_W-1:0]   rd_idx,
    input  logic               rd_en,
    output logic               rd_hit,
    output hpcs_pkg::payload_t rd_data
);

    logic [NSLOTS-1:0]  hit_reg;
    logic [NSLOTS-1:0]  hit_next;
    hpcs_pkg::payload_t mem [NSLOTS];

    always_comb
    begin
        hit_next = hit_reg;
        if (clear)
        begin
            hit_next = '0;
        end
        else if (wr_en)
        begin
            hit_next[wr_idx] = wr_hit;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg <= '0;
        end
        else
        begin
            hit_reg <= hit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_idx] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_idx];
        end
    end

    assign rd_hit = hit_reg[rd_idx];

`ifndef NO_ASSERTIONS
    a_no_write_during_clear: assert property (@(posedge clk) disable iff (!rst_n)
        !(wr_en && clear))
        else $error("slot write collides with flag clear");

    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        clear |=> hit_reg == '0)
        else $error("hit flags not empty after clear");
`endif

endmodule

// ===== rtl/highest_pt_candidate_selector_unit.sv =====
// Top level: slot loading, priority scan sequencer, result staging and config register.
//
// Usage:
//   Slave stream (s_*) carries one candidate slot per word; s_tlast marks the
//   final slot and starts a selection. Master stream (m_*) returns the selected
//   candidates in rank order, highest pt level first, m_tlast on the final one.
//   If no slot hit, a single word with found=0 and m_tlast=1 is returned.
//   Write APB register 0 (region_is_endcap) only while the block is idle; not enforced.
// Timing:
//   Slot words without tlast are accepted back to back while idle. A tlast word
//   starts a scan that visits one slot per cycle from the top pt level down, adds a
//   fetch state per hit read from the payload memory, and ends in a flush state;
//   s_tready stays low until the flush is done. A fetch waits while a candidate is
//   held and the output register is full. The scan stops as soon as OUT_SLOTS hits
//   are found. The single payload memory read port and the slot-per-cycle sequencer
//   set the scan rate.
// Reset clears the hit flags, the sequencer and the output valid flag. When the
// receiver stalls, fetch and flush wait on the output register; no word is lost.
module highest_pt_candidate_selector_unit #(
    parameter int PT_LEVELS = hpcs_pkg::PT_LEVELS_DEF,
    parameter int PRE_SLOTS = hpcs_pkg::PRE_SLOTS_DEF,
    parameter int OUT_SLOTS = hpcs_pkg::OUT_SLOTS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // slave stream
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // [3:0] pt_level, [4] slot_index, [5] hit, [10:6] subsector_id, [11] r_bit,
    // [13:12] phi_pos, [18:14] delta_r, [22:19] delta_phi, [23] veto_in
    input  logic [hpcs_pkg::IN_DATA_W-1:0] s_tdata,
    input  logic                           s_tlast,   // load_done
    // master stream
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [0] rank, [1] found, [5:2] sel_pt_level, [12:6] sel_r, [14:13] sel_phi,
    // [20:15] sel_delta_r, [24:21] sel_delta_phi, [25] sel_veto, [31:26] zero
    output logic [hpcs_pkg::OUT_DATA_W-1:0] m_tdata,
    output logic                           m_tlast,   // last_result
    // APB config
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [hpcs_pkg::ADDR_W-1:0]    paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);

    localparam int NSLOTS = PT_LEVELS * PRE_SLOTS;
    localparam int IDX_W  = (NSLOTS > 1) ? $clog2(NSLOTS) : 1;
    localparam int SLOT_W = (PRE_SLOTS > 1) ? $clog2(PRE_SLOTS) : 1;
    localparam int CNT_W  = $clog2(OUT_SLOTS + 1);
    localparam int RES_W  = $bits(hpcs_pkg::result_t);

    // config register
    logic endcap_reg;

    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            endcap_reg <= 1'b0;
        end
        else if (psel && penable && pwrite && pready
                 && paddr[2] == hpcs_pkg::REG_REGION_IS_ENDCAP)
        begin
            endcap_reg <= pwdata[0];
        end
    end

    assign prdata = (paddr[2] == hpcs_pkg::REG_REGION_IS_ENDCAP) ? {31'b0, endcap_reg} : '0;

    // input unpack
    logic [3:0]         in_pt;
    logic               in_slot;
    logic               in_hit;
    hpcs_pkg::payload_t in_payload;
    logic               in_fire;
    logic               in_wr_en;
    logic [IDX_W-1:0]   in_idx;

    assign in_pt              = s_tdata[3:0];
    assign in_slot            = s_tdata[4];
    assign in_hit             = s_tdata[5];
    assign in_payload.ssc     = s_tdata[10:6];
    assign in_payload.rb      = s_tdata[11];
    assign in_payload.phi     = s_tdata[13:12];
    assign in_payload.dr      = s_tdata[18:14];
    assign in_payload.dphi    = s_tdata[22:19];
    assign in_payload.veto    = s_tdata[23];

    assign in_fire  = s_tvalid && s_tready;
    assign in_wr_en = in_fire && (in_pt != 4'd0) && (32'(in_pt) <= PT_LEVELS)
                      && (32'(in_slot) < PRE_SLOTS);
    assign in_idx   = IDX_W'((32'(in_pt) - 32'd1) * PRE_SLOTS + 32'(in_slot));

    // sequencer state
    hpcs_pkg::state_t   state_reg, state_next;
    logic [3:0]         lvl_reg, lvl_next;
    logic [SLOT_W-1:0]  j_reg, j_next;
    logic [CNT_W-1:0]   found_cnt_reg, found_cnt_next;
    logic               hold_valid_reg, hold_valid_next;
    hpcs_pkg::result_t  hold_reg, hold_next;
    logic               out_valid_reg, out_valid_next;
    hpcs_pkg::result_t  out_word_reg, out_word_next;
    logic               out_last_reg, out_last_next;

    logic [IDX_W-1:0]   scan_idx;
    logic               scan_hit;
    logic               scan_at_end;
    logic               out_free;
    logic               rd_en;
    logic               clear;
    hpcs_pkg::payload_t rd_data;
    hpcs_pkg::result_t  fetched;
    logic [CNT_W-1:0]   found_inc;

    assign scan_idx    = IDX_W'((32'(lvl_reg) - 32'd1) * PRE_SLOTS + 32'(j_reg));
    assign scan_at_end = (lvl_reg == 4'd1) && (j_reg == SLOT_W'(PRE_SLOTS - 1));
    assign out_free    = !out_valid_reg || m_tready;
    assign found_inc   = found_cnt_reg + CNT_W'(1);
    assign fetched     = hpcs_pkg::fmt_result(rd_data, lvl_reg, found_cnt_reg[0], endcap_reg);

    assign s_tready = (state_reg == hpcs_pkg::ST_IDLE);
    assign rd_en    = (state_reg == hpcs_pkg::ST_SCAN) && scan_hit;
    assign clear    = (state_reg == hpcs_pkg::ST_FLUSH) && out_free;

    hpcs_slot_store #(
        .NSLOTS (NSLOTS),
        .IDX_W  (IDX_W)
    ) u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (in_wr_en),
        .wr_idx  (in_idx),
        .wr_hit  (in_hit),
        .wr_data (in_payload),
        .clear   (clear),
        .rd_idx  (scan_idx),
        .rd_en   (rd_en),
        .rd_hit  (scan_hit),
        .rd_data (rd_data)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            hpcs_pkg::ST_IDLE:
            begin
                if (in_fire && s_tlast)
                begin
                    state_next = hpcs_pkg::ST_SCAN;
                end
            end
            hpcs_pkg::ST_SCAN:
            begin
                if (scan_hit)
                begin
                    state_next = hpcs_pkg::ST_FETCH;
                end
                else if (scan_at_end)
                begin
                    state_next = hpcs_pkg::ST_FLUSH;
                end
            end
            hpcs_pkg::ST_FETCH:
            begin
                if (!hold_valid_reg || out_free)
                begin
                    if (found_inc == CNT_W'(OUT_SLOTS) || scan_at_end)
                    begin
                        state_next = hpcs_pkg::ST_FLUSH;
                    end
                    else
                    begin
                        state_next = hpcs_pkg::ST_SCAN;
                    end
                end
            end
            hpcs_pkg::ST_FLUSH:
            begin
                if (out_free)
                begin
                    state_next = hpcs_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = hpcs_pkg::ST_IDLE;
            end
        endcase
    end

    // datapath and output register
    always_comb
    begin
        lvl_next        = lvl_reg;
        j_next          = j_reg;
        found_cnt_next  = found_cnt_reg;
        hold_valid_next = hold_valid_reg;
        hold_next       = hold_reg;
        out_word_next   = out_word_reg;
        out_last_next   = out_last_reg;
        out_valid_next  = out_valid_reg && !m_tready;

        unique case (state_reg)
            hpcs_pkg::ST_IDLE:
            begin
                lvl_next = 4'(PT_LEVELS);
                j_next   = '0;
            end
            hpcs_pkg::ST_SCAN:
            begin
                if (!scan_hit && !scan_at_end)
                begin
                    if (j_reg == SLOT_W'(PRE_SLOTS - 1))
                    begin
                        j_next   = '0;
                        lvl_next = lvl_reg - 4'd1;
                    end
                    else
                    begin
                        j_next = j_reg + SLOT_W'(1);
                    end
                end
            end
            hpcs_pkg::ST_FETCH:
            begin
                if (!hold_valid_reg || out_free)
                begin
                    // the held candidate is not the last: a later hit exists
                    if (hold_valid_reg)
                    begin
                        out_word_next  = hold_reg;
                        out_last_next  = 1'b0;
                        out_valid_next = 1'b1;
                    end
                    hold_next       = fetched;
                    hold_valid_next = 1'b1;
                    found_cnt_next  = found_inc;
                    if (!scan_at_end)
                    begin
                        if (j_reg == SLOT_W'(PRE_SLOTS - 1))
                        begin
                            j_next   = '0;
                            lvl_next = lvl_reg - 4'd1;
                        end
                        else
                        begin
                            j_next = j_reg + SLOT_W'(1);
                        end
                    end
                end
            end
            hpcs_pkg::ST_FLUSH:
            begin
                if (out_free)
                begin
                    out_word_next   = hold_valid_reg ? hold_reg : hpcs_pkg::result_t'('0);
                    out_last_next   = 1'b1;
                    out_valid_next  = 1'b1;
                    hold_valid_next = 1'b0;
                    found_cnt_next  = '0;
                end
            end
            default:
            begin
                found_cnt_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= hpcs_pkg::ST_IDLE;
            lvl_reg        <= '0;
            j_reg          <= '0;
            found_cnt_reg  <= '0;
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            lvl_reg        <= lvl_next;
            j_reg          <= j_next;
            found_cnt_reg  <= found_cnt_next;
            hold_valid_reg <= hold_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hold_reg     <= hold_next;
        out_word_reg <= out_word_next;
        out_last_reg <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(hpcs_pkg::OUT_DATA_W - RES_W)'(0), out_word_reg};
    assign m_tlast  = out_last_reg;

`ifndef NO_ASSERTIONS
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(found_cnt_reg) <= OUT_SLOTS)
        else $error("found count above OUT_SLOTS");

    a_hold_counted: assert property (@(posedge clk) disable iff (!rst_n)
        hold_valid_reg |-> found_cnt_reg != '0)
        else $error("held candidate without count");

    a_flush_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == hpcs_pkg::ST_FLUSH && out_free)
        |=> (state_reg == hpcs_pkg::ST_IDLE && m_tvalid && m_tlast && !hold_valid_reg))
        else $error("selection did not close with a last word");

    a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == hpcs_pkg::ST_IDLE |-> (found_cnt_reg == '0 && !hold_valid_reg))
        else $error("idle with pending candidate");
`endif

endmodule

// ===== tb/hpcs_sb_pkg.sv =====
// Slot word layout, result predictor and scoreboard for the candidate selector testbench.
package hpcs_sb_pkg;

    localparam int NSLOTS   = hpcs_pkg::PT_LEVELS_DEF * hpcs_pkg::PRE_SLOTS_DEF;
    localparam int MAX_SHOW = 10;

    // slave tdata layout, lowest bits last
    typedef struct packed {
        logic       veto;
        logic [3:0] dphi;
        logic [4:0] dr;
        logic [1:0] phi;
        logic       rb;
        logic [4:0] ssc;
        logic       hit;
        logic       slot;
        logic [3:0] pt;
    } slot_word_t;

    typedef struct {
        hpcs_pkg::result_t res;
        logic              last;
    } sel_word_t;

    class hpcs_scoreboard;

        logic               endcap;
        int                 errors;
        logic               hit_flag [NSLOTS];
        hpcs_pkg::payload_t payload [NSLOTS];
        sel_word_t          sel_q [$];

        function new();
            endcap = 1'b0;
            errors = 0;
            foreach (hit_flag[i])
                hit_flag[i] = 1'b0;
        endfunction

        function void set_endcap(logic value);
            endcap = value;
        endfunction

        function int pending();
            return sel_q.size();
        endfunction

        function void flag(string msg);
            errors++;
            if (errors <= MAX_SHOW)
                $display("ERROR: %s", msg);
        endfunction

        // Load the slot; on the last word, scan top level down and queue the picks.
        function void note_word(slot_word_t w, logic last);
            int                 idx;
            int                 n;
            int                 lvl;
            int                 j;
            int                 r;
            int                 d;
            hpcs_pkg::payload_t p;
            sel_word_t          e;
            n = 0;
            if (w.pt >= 1 && int'(w.pt) <= hpcs_pkg::PT_LEVELS_DEF
                && int'(w.slot) < hpcs_pkg::PRE_SLOTS_DEF)
            begin
                idx = (int'(w.pt) - 1) * hpcs_pkg::PRE_SLOTS_DEF + int'(w.slot);
                hit_flag[idx] = w.hit;
                payload[idx]  = {w.ssc, w.rb, w.phi, w.dr, w.dphi, w.veto};
            end
            if (!last)
                return;
            for (lvl = hpcs_pkg::PT_LEVELS_DEF; lvl >= 1 && n < hpcs_pkg::OUT_SLOTS_DEF; lvl--)
            begin
                for (j = 0; j < hpcs_pkg::PRE_SLOTS_DEF && n < hpcs_pkg::OUT_SLOTS_DEF; j++)
                begin
                    idx = (lvl - 1) * hpcs_pkg::PRE_SLOTS_DEF + j;
                    if (!hit_flag[idx])
                        continue;
                    p = payload[idx];
                    r = 2 * int'(p.ssc) + int'(p.rb) - int'(endcap);
                    d = 2 * int'($signed(p.dr));
                    e.res.rank  = n[0];
                    e.res.found = 1'b1;
                    e.res.lvl   = lvl[3:0];
                    e.res.r     = r[6:0];
                    e.res.phi   = p.phi;
                    e.res.dr    = d[5:0];
                    e.res.dphi  = p.dphi;
                    e.res.veto  = p.veto;
                    e.last      = 1'b0;
                    sel_q.push_back(e);
                    n++;
                end
            end
            foreach (hit_flag[i])
                hit_flag[i] = 1'b0;
            if (n == 0)
            begin
                e.res  = '0;
                e.last = 1'b1;
                sel_q.push_back(e);
            end
            else
            begin
                sel_q[sel_q.size() - 1].last = 1'b1;
            end
        endfunction

        function void check_word(logic [hpcs_pkg::OUT_DATA_W-1:0] data, logic last);
            hpcs_pkg::result_t got;
            sel_word_t         e;
            string             exp_s;
            string             got_s;
            got = data[$bits(hpcs_pkg::result_t)-1:0];
            if (sel_q.size() == 0)
            begin
                flag($sformatf("unexpected word %h last=%b", data, last));
                return;
            end
            e = sel_q.pop_front();
            if (got.rank !== e.res.rank || got.found !== e.res.found ||
                got.lvl !== e.res.lvl || got.r !== e.res.r || got.phi !== e.res.phi ||
                got.dr !== e.res.dr || got.dphi !== e.res.dphi ||
                got.veto !== e.res.veto || last !== e.last ||
                data[hpcs_pkg::OUT_DATA_W-1:$bits(hpcs_pkg::result_t)] !== '0)
            begin
                exp_s = $sformatf("exp rank=%0d found=%0d lvl=%0d r=%0d phi=%0d dr=%0d",
                                  e.res.rank, e.res.found, e.res.lvl, $signed(e.res.r),
                                  e.res.phi, $signed(e.res.dr));
                exp_s = {exp_s, $sformatf(" dphi=%0d veto=%0d last=%0d",
                                          $signed(e.res.dphi), e.res.veto, e.last)};
                got_s = $sformatf("got rank=%0d found=%0d lvl=%0d r=%0d phi=%0d dr=%0d",
                                  got.rank, got.found, got.lvl, $signed(got.r),
                                  got.phi, $signed(got.dr));
                got_s = {got_s, $sformatf(" dphi=%0d veto=%0d last=%0d pad=%h",
                                          $signed(got.dphi), got.veto, last,
                                          data[hpcs_pkg::OUT_DATA_W-1:
                                               $bits(hpcs_pkg::result_t)])};
                flag({"word mismatch: ", exp_s, " | ", got_s});
            end
        endfunction

    endclass

endpackage

// ===== tb/tb_highest_pt_candidate_selector_unit.sv =====
// Stream and register level testbench for the highest-pt candidate selector unit.
module tb_highest_pt_candidate_selector_unit;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SCAN_CYCLES  = hpcs_pkg::PT_LEVELS_DEF * hpcs_pkg::PRE_SLOTS_DEF
                                  + hpcs_pkg::OUT_SLOTS_DEF + 8;
    localparam int PHASE_ITEMS  = 150;
    localparam int HOLD_CYCLES  = 300;
    localparam int TIMEOUT_NS   = 5_000_000;
    localparam logic [hpcs_pkg::ADDR_W-1:0] ADDR_ENDCAP =
        {hpcs_pkg::REG_REGION_IS_ENDCAP, 2'b00};

    logic                            clk;
    logic                            rst_n    = 1'b0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [hpcs_pkg::IN_DATA_W-1:0]  s_tdata  = '0;
    logic                            s_tlast  = 1'b0;
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    logic [hpcs_pkg::OUT_DATA_W-1:0] m_tdata;
    logic                            m_tlast;
    logic                            psel     = 1'b0;
    logic                            penable  = 1'b0;
    logic                            pwrite   = 1'b0;
    logic [hpcs_pkg::ADDR_W-1:0]     paddr    = '0;
    logic [31:0]                     pwdata   = '0;
    logic [31:0]                     prdata;
    logic                            pready;

    int   send_idle_pct  = 0;
    int   recv_stall_pct = 0;
    int   hold_seq       = 0;
    int   hold_ack       = 0;
    int   hold_left      = 0;

    hpcs_sb_pkg::hpcs_scoreboard sb;

    highest_pt_candidate_selector_unit u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("highest_pt_candidate_selector_unit test failed");
        $finish;
    end

    // Receiver: random stalls, plus a long hold-off on request.
    always @(posedge clk)
    begin
        if (hold_ack != hold_seq)
        begin
            hold_ack  <= hold_seq;
            hold_left <= HOLD_CYCLES;
            m_tready  <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end
        else
        begin
            m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
            sb.note_word(hpcs_sb_pkg::slot_word_t'(s_tdata), s_tlast);
        if (rst_n && m_tvalid && m_tready)
            sb.check_word(m_tdata, m_tlast);
    end

    function automatic hpcs_sb_pkg::slot_word_t mk_word(int pt, int slot, int hit, int ssc,
                                                        int rb, int phi, int dr, int dphi,
                                                        int veto);
        hpcs_sb_pkg::slot_word_t w;
        w.pt   = pt[3:0];
        w.slot = slot[0];
        w.hit  = hit[0];
        w.ssc  = ssc[4:0];
        w.rb   = rb[0];
        w.phi  = phi[1:0];
        w.dr   = dr[4:0];
        w.dphi = dphi[3:0];
        w.veto = veto[0];
        return w;
    endfunction

    function automatic hpcs_sb_pkg::slot_word_t rand_word(int hit_pct);
        hpcs_sb_pkg::slot_word_t w;
        logic [31:0]             raw;
        raw = $urandom;
        w   = raw[$bits(hpcs_sb_pkg::slot_word_t)-1:0];
        // pt level 0 is out of range and only rarely offered
        w.pt  = ($urandom_range(0, 15) == 0) ? 4'd0
                : 4'($urandom_range(1, hpcs_pkg::PT_LEVELS_DEF));
        w.hit = ($urandom_range(0, 99) < hit_pct);
        return w;
    endfunction

    task automatic send_word(hpcs_sb_pkg::slot_word_t w, logic last);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= w;
        s_tlast  <= last;
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    // One selection: random slot words, the final one carrying tlast.
    task automatic send_frame(output int loaded);
        int                      len;
        int                      hit_pct;
        int                      pick;
        hpcs_sb_pkg::slot_word_t w;
        loaded = 0;
        pick = $urandom_range(0, 9);
        len  = (pick == 0) ? 1 : $urandom_range(2, 10);
        case ($urandom_range(0, 3))
            0:       hit_pct = 0;
            1:       hit_pct = 10;
            2:       hit_pct = 40;
            default: hit_pct = 80;
        endcase
        for (int k = 0; k < len; k++)
        begin
            w = rand_word(hit_pct);
            if (w.pt != 4'd0)
                loaded++;
            send_word(w, k == len - 1);
        end
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SCAN_CYCLES) @(posedge clk);
    endtask

    task automatic apb_write(logic value);
        logic [31:0] data;
        data    = $urandom;
        data[0] = value;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_ENDCAP;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.set_endcap(value);
        @(posedge clk);
    endtask

    task automatic apb_check();
        logic [31:0] data;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= ADDR_ENDCAP;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        data = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (data !== {31'b0, sb.endcap})
            sb.flag($sformatf("register read %h, exp %0d", data, sb.endcap));
        @(posedge clk);
    endtask

    initial
    begin
        int loaded;
        int items;
        int frames;
        sb = new();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        apb_check();
        apb_write(1'b1);
        apb_check();

        // nothing hit
        send_word(mk_word(5, 0, 0, 3, 1, 2, 4, -3, 1), 1'b1);
        // two hits at the top level, extremes of every payload field
        send_word(mk_word(15, 0, 1, 31, 1, 3, -16, -8, 1), 1'b0);
        send_word(mk_word(15, 1, 1, 0, 0, 0, 15, 7, 0), 1'b0);
        send_word(mk_word(1, 0, 1, 12, 1, 1, 3, 2, 1), 1'b1);
        // single hit, R goes negative with endcap set
        send_word(mk_word(1, 1, 1, 0, 0, 2, -1, -1, 1), 1'b1);
        // out of range level, and a hit overwritten by a miss
        send_word(mk_word(0, 0, 1, 9, 0, 1, 5, 5, 0), 1'b0);
        send_word(mk_word(3, 1, 1, 7, 1, 3, -15, -7, 1), 1'b0);
        send_word(mk_word(3, 1, 0, 7, 1, 3, -15, -7, 1), 1'b0);
        send_word(mk_word(7, 0, 1, 20, 0, 0, 8, -4, 0), 1'b1);
        // last word on an out of range level still starts a selection
        send_word(mk_word(0, 1, 1, 31, 1, 3, 15, 7, 1), 1'b1);
        // more hits than output slots: highest levels win
        send_word(mk_word(2, 0, 1, 1, 0, 1, 1, 1, 0), 1'b0);
        send_word(mk_word(2, 1, 1, 2, 1, 2, -2, -2, 1), 1'b0);
        send_word(mk_word(9, 1, 1, 16, 0, 3, 10, 6, 0), 1'b1);
        // within a level, slot order decides, not load order
        send_word(mk_word(14, 1, 1, 30, 1, 1, -9, 3, 1), 1'b0);
        send_word(mk_word(14, 0, 1, 15, 0, 2, 9, -5, 0), 1'b0);
        send_word(mk_word(4, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1);
        drain();

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct  = 85;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 85;
                end
                default:
                begin
                    send_idle_pct  = 15;
                    recv_stall_pct = 15;
                end
            endcase
            apb_write(phase[0]);
            apb_check();
            items  = 0;
            frames = 0;
            while (items < PHASE_ITEMS)
            begin
                if (phase == 0 && frames == 3)
                    hold_seq <= hold_seq + 1;
                if (phase == 2 && frames == 5)
                begin
                    // let the block empty out completely before going on
                    s_tvalid <= 1'b0;
                    @(posedge clk);
                    while (sb.pending() != 0)
                        @(posedge clk);
                end
                send_frame(loaded);
                items += loaded;
                frames++;
            end
            drain();
        end

        if (sb.errors == 0 && sb.pending() == 0)
            $display("highest_pt_candidate_selector_unit test passed");
        else
            $display("highest_pt_candidate_selector_unit test failed");
        $finish;
    end

endmodule
